FILE: hdl/wpf_pkg.sv
// ----------------------------------------------------------------------------
// wpf_pkg
// shared types and constants of the word packet framer
// ----------------------------------------------------------------------------
package wpf_pkg;

  // framing bytes
  localparam logic [7:0] HDR_A = 8'h2A;  // '*'
  localparam logic [7:0] HDR_B = 8'h23;  // '#'
  localparam logic [7:0] TRL_A = 8'h40;  // '@'
  localparam logic [7:0] TRL_B = 8'h21;  // '!'

  // byte slots of one item, in stream order
  localparam int          NUM_SLOTS  = 7;
  localparam logic [2:0]  SLOT_HDR_A = 3'd0;
  localparam logic [2:0]  SLOT_HDR_B = 3'd1;
  localparam logic [2:0]  SLOT_HI    = 3'd2;
  localparam logic [2:0]  SLOT_LO    = 3'd3;
  localparam logic [2:0]  SLOT_CSUM  = 3'd4;
  localparam logic [2:0]  SLOT_TRL_A = 3'd5;
  localparam logic [2:0]  SLOT_TRL_B = 3'd6;

  // classified item as held in the queue
  typedef struct packed {
    logic [15:0] word;
    logic        first;
    logic        last;
    logic        no_data;
    logic [7:0]  csum;     // checksum after this item's word
  } wpf_entry_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } wpf_qstat_t;

endpackage

FILE: hdl/word_packet_framer_xor.sv
// ----------------------------------------------------------------------------
// word_packet_framer_xor
// frames packets of 16-bit words into a byte stream with an xor checksum
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries one item per transfer: a word
//   with first, last and no_data flags. output channel (out_valid / out_stall)
//   carries one byte per transfer, with run_end on the last byte of an item
//   and frame_end on the closing '!' of a packet.
//   an item yields header "*#" if first, its two word bytes unless no_data,
//   and checksum, "@", "!" if last; items that yield nothing are absorbed.
//   input to output: when the queue is empty, the first byte of an item
//   passes the queue head, written at the transfer edge, and then the output
//   register before it is offered.
//   throughput: one output byte per cycle while the receiver does not stall,
//   set by the single output register; a mid-packet word yields 2 bytes, an
//   item from 2 up to 7 bytes. the front accepts a new item every cycle while
//   the queue of QUEUE_DEPTH entries has room.
//   reset: synchronous, active low; clears the checksum, empties the queue
//   and drops the output valid.
//   stall: when the receiver stalls, the output byte holds, the back stops,
//   the queue fills and in_stall rises once the queue is full.
// ----------------------------------------------------------------------------
module word_packet_framer_xor #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_word,
  input  logic        in_first,
  input  logic        in_last,
  input  logic        in_no_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_run_end,
  output logic        out_frame_end
);

  // front to queue
  logic                q_push;
  wpf_pkg::wpf_entry_t q_wdata;
  // queue to back
  logic                q_pop;
  wpf_pkg::wpf_entry_t q_head;
  wpf_pkg::wpf_qstat_t qstat;

  // front: takes items, updates the checksum, classifies and queues
  wpf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .in_first   (in_first),
    .in_last    (in_last),
    .in_no_data (in_no_data),
    .qstat      (qstat),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  // queue decouples the item rate from the byte rate
  wpf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .head  (q_head),
    .qstat (qstat)
  );

  // back: emits the bytes of the head item, one per cycle unless the receiver stalls
  wpf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (q_head),
    .qstat         (qstat),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_run_end   (out_run_end),
    .out_frame_end (out_frame_end)
  );

  // a full queue never takes a push
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.full |-> !q_push)
    else $error("push into full queue");

  // the back only pops a present entry
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !qstat.empty)
    else $error("pop from empty queue");

  // the packet close is the trailer byte and ends its item
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |-> (out_run_end && (out_byte == wpf_pkg::TRL_B)))
    else $error("frame end on wrong byte");

  // a byte that ends its item left the queue when it was produced
  a_run_end_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !out_stall) |=> (out_valid && out_run_end))
    else $error("run end does not follow pop");

endmodule

FILE: hdl/wpf_front.sv
// ----------------------------------------------------------------------------
// wpf_front
// accepts items, keeps the running checksum and queues items with output
// ----------------------------------------------------------------------------
module wpf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_word,
  input  logic               in_first,
  input  logic               in_last,
  input  logic               in_no_data,
  input  wpf_pkg::wpf_qstat_t qstat,
  output logic               q_push,
  output wpf_pkg::wpf_entry_t q_wdata
);

  logic [7:0] xor_r;
  logic [7:0] xor_nxt;
  logic [7:0] xor_base;
  logic       accept;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !qstat.full;

  // opening item clears the checksum before its own word
  assign xor_base = in_first ? 8'h00 : xor_r;
  always_comb begin
    xor_nxt = xor_r;
    if (accept) begin
      xor_nxt = in_no_data ? xor_base : (xor_base ^ in_word[15:8] ^ in_word[7:0]);
    end
  end

  // items that emit nothing never reach the queue
  assign q_push = accept && (in_first || in_last || !in_no_data);

  assign q_wdata.word    = in_word;
  assign q_wdata.first   = in_first;
  assign q_wdata.last    = in_last;
  assign q_wdata.no_data = in_no_data;
  assign q_wdata.csum    = xor_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_r <= 8'h00;
    end else begin
      xor_r <= xor_nxt;
    end
  end

endmodule

FILE: hdl/wpf_fifo.sv
// ----------------------------------------------------------------------------
// wpf_fifo
// short queue between front and back with a registered head entry
// ----------------------------------------------------------------------------
module wpf_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wpf_pkg::wpf_entry_t wdata,
  input  logic                pop,
  output wpf_pkg::wpf_entry_t head,
  output wpf_pkg::wpf_qstat_t qstat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wpf_pkg::wpf_entry_t mem [DEPTH];
  wpf_pkg::wpf_entry_t head_r;

  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r;
  logic [AW-1:0] rd_ptr_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + AW'(1);
    end
    return r;
  endfunction

  assign wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
  assign rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign qstat.full  = (count_r == CW'(DEPTH));
  assign qstat.empty = (count_r == '0);
  assign head        = head_r;

  // storage and head read, with bypass when the new head is written now
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
    if (push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= wdata;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: hdl/wpf_back.sv
// ----------------------------------------------------------------------------
// wpf_back
// walks the byte slots of the queue head and drives the output register
// ----------------------------------------------------------------------------
module wpf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  wpf_pkg::wpf_entry_t head,
  input  wpf_pkg::wpf_qstat_t qstat,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                out_run_end,
  output logic                out_frame_end
);

  localparam int NS = wpf_pkg::NUM_SLOTS;

  logic          loaded_r;
  logic          loaded_nxt;
  logic [NS-1:0] rem_r;
  logic [NS-1:0] rem_nxt;
  logic [NS-1:0] mask_init;
  logic [NS-1:0] mask;
  logic [NS-1:0] sel_bit;
  logic [NS-1:0] rem_left;
  logic [2:0]    sel;
  logic          slot_free;
  logic          emit;
  logic [7:0]    byte_sel;

  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_run_end_r;
  logic          out_frame_end_r;

  assign mask_init = {head.last, head.last, head.last, !head.no_data, !head.no_data,
                      head.first, head.first};
  assign mask      = loaded_r ? rem_r : mask_init;

  // lowest pending slot
  always_comb begin
    sel = 3'd0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        sel = 3'(i);
      end
    end
  end

  assign sel_bit  = NS'(1) << sel;
  assign rem_left = mask & ~sel_bit;

  assign slot_free = !out_valid_r || !out_stall;
  assign emit      = !qstat.empty && slot_free;
  assign q_pop     = emit && (rem_left == '0);

  always_comb begin
    case (sel)
      wpf_pkg::SLOT_HDR_A: byte_sel = wpf_pkg::HDR_A;
      wpf_pkg::SLOT_HDR_B: byte_sel = wpf_pkg::HDR_B;
      wpf_pkg::SLOT_HI:    byte_sel = head.word[15:8];
      wpf_pkg::SLOT_LO:    byte_sel = head.word[7:0];
      wpf_pkg::SLOT_CSUM:  byte_sel = head.csum;
      wpf_pkg::SLOT_TRL_A: byte_sel = wpf_pkg::TRL_A;
      wpf_pkg::SLOT_TRL_B: byte_sel = wpf_pkg::TRL_B;
      default:             byte_sel = 8'h00;
    endcase
  end

  always_comb begin
    loaded_nxt = loaded_r;
    rem_nxt    = rem_r;
    if (emit) begin
      loaded_nxt = (rem_left != '0);
      rem_nxt    = rem_left;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      loaded_r <= loaded_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    if (emit) begin
      out_byte_r      <= byte_sel;
      out_run_end_r   <= (rem_left == '0);
      out_frame_end_r <= (sel == wpf_pkg::SLOT_TRL_B);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_run_end   = out_run_end_r;
  assign out_frame_end = out_frame_end_r;

endmodule
